// ----- sv/acpm_pkg.sv -----
package acpm_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
   localparam int SAMPLE_W     = 32;
   localparam int COUNT_REG_W  = 4;
   localparam int INDEX_W      = 3;
   localparam int FRAC_W       = 16;
   localparam int LEVEL_W      = FRAC_W + 1;
   localparam int RSP_DATA_W   = ((INDEX_W + LEVEL_W + 7) / 8) * 8;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_W;

   typedef enum logic [1:0] {
      WIDTH_8   = 2'd0,
      WIDTH_16  = 2'd1,
      WIDTH_32  = 2'd2,
      WIDTH_BAD = 2'd3
   } width_type;

   typedef enum logic [1:0] {
      REG_SIGNED    = 2'd0,
      REG_WIDTH     = 2'd1,
      REG_COUNT     = 2'd2,
      REG_SUPPORTED = 2'd3
   } reg_type;

   typedef struct packed {
      logic                   sample_signed;
      width_type              width_code;
      logic [COUNT_REG_W-1:0] channel_count;
      logic                   format_supported;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mag;
      logic [CH_W-1:0]     pos;
      logic                buffer_end;
   } slot_type;

   function automatic logic [CNT_W-1:0] eff_count(input cfg_type cfg);
      logic [CNT_W-1:0] res;
      if (cfg.channel_count == '0) begin
         res = CNT_W'(1);
      end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
         res = CNT_W'(MAX_CHANNELS);
      end else begin
         res = CNT_W'(cfg.channel_count);
      end
      return res;
   endfunction

   // full-scale value of the format, zero for the unused width code
   function automatic logic [SAMPLE_W-1:0] format_peak(input cfg_type cfg);
      logic [SAMPLE_W-1:0] res;
      unique case (cfg.width_code)
         WIDTH_8:   res = cfg.sample_signed ? 32'h0000_007F : 32'h0000_00FF;
         WIDTH_16:  res = cfg.sample_signed ? 32'h0000_7FFF : 32'h0000_FFFF;
         WIDTH_32:  res = cfg.sample_signed ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
         WIDTH_BAD: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ----- sv/acpm_front.sv -----
module acpm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  acpm_pkg::cfg_type                 cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [acpm_pkg::SAMPLE_W-1:0]     req_tdata,
   input  logic                              req_tlast,
   input  logic                              fifo_full,
   output logic                              push,
   output acpm_pkg::slot_type                slot
);

   logic [acpm_pkg::CH_W-1:0]     pos_ff;
   logic [acpm_pkg::CH_W-1:0]     pos_in;
   logic [acpm_pkg::CH_W-1:0]     cur_pos;
   logic [acpm_pkg::CNT_W-1:0]    count;
   logic [acpm_pkg::CNT_W-1:0]    nxt_pos;
   logic [acpm_pkg::SAMPLE_W-1:0] v;
   logic [acpm_pkg::SAMPLE_W-1:0] sgn;
   logic [acpm_pkg::SAMPLE_W:0]   neg_mag;
   logic                          neg;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;
   assign count      = acpm_pkg::eff_count(cfg);
   assign cur_pos    = (acpm_pkg::CNT_W'(pos_ff) >= count) ? '0 : pos_ff;
   assign nxt_pos    = acpm_pkg::CNT_W'(cur_pos) + acpm_pkg::CNT_W'(1);

   always_comb begin
      unique case (cfg.width_code)
         acpm_pkg::WIDTH_8: begin
            v   = {24'b0, req_tdata[7:0]};
            sgn = 32'h0000_0080;
         end
         acpm_pkg::WIDTH_16: begin
            v   = {16'b0, req_tdata[15:0]};
            sgn = 32'h0000_8000;
         end
         acpm_pkg::WIDTH_32, acpm_pkg::WIDTH_BAD: begin
            v   = req_tdata;
            sgn = 32'h8000_0000;
         end
      endcase
   end

   // negative sample: magnitude is twice the sign weight minus the raw code
   assign neg     = cfg.sample_signed && ((v & sgn) != '0);
   assign neg_mag = {sgn, 1'b0} - {1'b0, v};

   always_comb begin
      slot.mag        = neg ? neg_mag[acpm_pkg::SAMPLE_W-1:0] : v;
      slot.pos        = cur_pos;
      slot.buffer_end = req_tlast;
   end

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         if (req_tlast || nxt_pos >= count) begin
            pos_in = '0;
         end else begin
            pos_in = nxt_pos[acpm_pkg::CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- sv/acpm_fifo.sv -----
module acpm_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  acpm_pkg::slot_type push_data,
   output logic               full,
   input  logic               pop,
   output acpm_pkg::slot_type pop_data,
   output logic               not_empty
);

   acpm_pkg::slot_type mem [acpm_pkg::FIFO_DEPTH];

   logic [acpm_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [acpm_pkg::FIFO_PTR_W-1:0] wr_ptr_in;
   logic [acpm_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [acpm_pkg::FIFO_PTR_W-1:0] rd_ptr_in;
   logic [acpm_pkg::FIFO_PTR_W:0]   count_ff;
   logic [acpm_pkg::FIFO_PTR_W:0]   count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full      = (count_ff == (acpm_pkg::FIFO_PTR_W + 1)'(acpm_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == acpm_pkg::FIFO_PTR_W'(acpm_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + acpm_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == acpm_pkg::FIFO_PTR_W'(acpm_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + acpm_pkg::FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (acpm_pkg::FIFO_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (acpm_pkg::FIFO_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/acpm_back.sv -----
module acpm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  acpm_pkg::cfg_type                   cfg,
   input  logic                                slot_valid,
   input  acpm_pkg::slot_type                  slot,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [acpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int STEP_W = (acpm_pkg::FRAC_W > 1) ? $clog2(acpm_pkg::FRAC_W) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_DIV,
      ST_PUSH
   } state_type;

   state_type                        state_ff;
   logic [acpm_pkg::SAMPLE_W-1:0]    peak_ff [acpm_pkg::MAX_CHANNELS];
   logic [acpm_pkg::CH_W-1:0]        ch_ff;
   logic [acpm_pkg::SAMPLE_W:0]      num_ff;
   logic [acpm_pkg::SAMPLE_W-1:0]    rem_ff;
   logic [acpm_pkg::FRAC_W-1:0]      quo_ff;
   logic [STEP_W-1:0]                step_ff;
   logic [acpm_pkg::LEVEL_W-1:0]     level_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [acpm_pkg::INDEX_W-1:0]     rsp_index_ff;
   logic [acpm_pkg::LEVEL_W-1:0]     rsp_level_ff;
   logic                             rsp_last_ff;

   logic [acpm_pkg::CH_W-1:0]        rd_idx;
   logic [acpm_pkg::SAMPLE_W-1:0]    rd_val;
   logic [acpm_pkg::SAMPLE_W-1:0]    fp;
   logic [acpm_pkg::SAMPLE_W:0]      fp_x;
   logic [acpm_pkg::SAMPLE_W:0]      twice;
   logic [acpm_pkg::SAMPLE_W:0]      num_calc;
   logic [acpm_pkg::SAMPLE_W:0]      trial;
   logic                             take;
   logic [acpm_pkg::SAMPLE_W:0]      rem_diff;
   logic [acpm_pkg::SAMPLE_W-1:0]    rem_step;
   logic [acpm_pkg::FRAC_W-1:0]      quo_step;
   logic [acpm_pkg::CNT_W-1:0]       count;
   logic                             last_ch;
   logic                             out_free;

   assign pop      = (state_ff == ST_IDLE) && slot_valid;
   assign rd_idx   = (state_ff == ST_IDLE) ? slot.pos : ch_ff;
   assign rd_val   = peak_ff[rd_idx];
   assign fp       = acpm_pkg::format_peak(cfg);
   assign fp_x     = {1'b0, fp};
   assign count    = acpm_pkg::eff_count(cfg);
   assign last_ch  = (acpm_pkg::CNT_W'(ch_ff) + acpm_pkg::CNT_W'(1) == count);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = ((state_ff == ST_PUSH) && out_free) || (rsp_valid_ff && !rsp_tready);

   // unsigned formats measure distance from mid-scale
   assign twice    = {rd_val, 1'b0};
   assign num_calc = cfg.sample_signed ? {1'b0, rd_val} :
                     (twice >= fp_x) ? (twice - fp_x) : (fp_x - twice);

   // restoring divide, one quotient bit per cycle; remainder stays below the peak
   assign trial    = {rem_ff, 1'b0};
   assign take     = (trial >= fp_x);
   assign rem_diff = trial - fp_x;
   assign rem_step = take ? rem_diff[acpm_pkg::SAMPLE_W-1:0] : trial[acpm_pkg::SAMPLE_W-1:0];
   assign quo_step = {quo_ff[acpm_pkg::FRAC_W-2:0], take};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(acpm_pkg::RSP_DATA_W - acpm_pkg::LEVEL_W - acpm_pkg::INDEX_W){1'b0}},
                        rsp_level_ff, rsp_index_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < acpm_pkg::MAX_CHANNELS; i++) begin
            peak_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (slot_valid) begin
                  if (slot.mag > rd_val) begin
                     peak_ff[slot.pos] <= slot.mag;
                  end
                  if (slot.buffer_end) begin
                     ch_ff    <= '0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               num_ff   <= num_calc;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (!cfg.format_supported || fp == '0) begin
                  level_ff <= '0;
                  state_ff <= ST_PUSH;
               end else if (num_ff >= fp_x) begin
                  level_ff <= acpm_pkg::LEVEL_ONE;
                  state_ff <= ST_PUSH;
               end else begin
                  rem_ff   <= num_ff[acpm_pkg::SAMPLE_W-1:0];
                  quo_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_step;
               quo_ff  <= quo_step;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(acpm_pkg::FRAC_W - 1)) begin
                  level_ff <= {1'b0, quo_step};
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (out_free) begin
                  rsp_index_ff <= acpm_pkg::INDEX_W'(ch_ff);
                  rsp_level_ff <= level_ff;
                  rsp_last_ff  <= last_ch;
                  if (last_ch) begin
                     for (int i = 0; i < acpm_pkg::MAX_CHANNELS; i++) begin
                        peak_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + acpm_pkg::CH_W'(1);
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- sv/audio_channel_peak_meter_top.sv -----
// Per-channel audio peak level meter.
// req_*: one interleaved PCM sample per item; tdata holds sample_bits,
//   tlast marks the final sample of a buffer. Sample k of a buffer belongs
//   to channel k mod channel_count (0 acts as 1, counts above 8 as 8).
// rsp_*: after a buffer ends, one item per channel, channel 0 first; tlast
//   on the last channel. Level is 1.16 unsigned, saturated at 1.0.
// csr_*: register write port (0 signed, 1 width code, 2 channel count,
//   3 format supported). csr_ready is always high.
// Throughput: one sample per cycle while the engine is idle. A two-entry queue
//   sits between the sample front end and the peak/normalize engine.
// At a buffer end the engine takes each channel in turn through load,
//   check, a bit-serial divide when the level needs it (one quotient bit
//   per cycle) and push; samples queue meanwhile.
// Reset: registers return to signed 16-bit, one channel, supported; all
//   channel peaks clear to zero. A stalled rsp holds its item; the engine
//   waits, the queue fills and req_tready drops.
module audio_channel_peak_meter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [acpm_pkg::SAMPLE_W-1:0]       req_tdata,   // [31:0] sample_bits
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [acpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [2:0] channel_index, [19:3] level
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [acpm_pkg::COUNT_REG_W-1:0]    csr_wdata
);

   acpm_pkg::cfg_type  cfg_ff;
   acpm_pkg::slot_type push_slot;
   acpm_pkg::slot_type pop_slot;
   logic               push;
   logic               pop;
   logic               fifo_full;
   logic               fifo_not_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_signed    <= 1'b1;
         cfg_ff.width_code       <= acpm_pkg::WIDTH_16;
         cfg_ff.channel_count    <= acpm_pkg::COUNT_REG_W'(1);
         cfg_ff.format_supported <= 1'b1;
      end else if (csr_valid) begin
         unique case (acpm_pkg::reg_type'(csr_index))
            acpm_pkg::REG_SIGNED:    cfg_ff.sample_signed    <= csr_wdata[0];
            acpm_pkg::REG_WIDTH:     cfg_ff.width_code <= acpm_pkg::width_type'(csr_wdata[1:0]);
            acpm_pkg::REG_COUNT:     cfg_ff.channel_count    <= csr_wdata;
            acpm_pkg::REG_SUPPORTED: cfg_ff.format_supported <= csr_wdata[0];
         endcase
      end
   end

   acpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .slot       (push_slot)
   );

   acpm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_slot),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_slot),
      .not_empty (fifo_not_empty)
   );

   acpm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .slot_valid (fifo_not_empty),
      .slot       (pop_slot),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/acpm_checker.sv -----
module acpm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [acpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   localparam int LVL_LO = acpm_pkg::INDEX_W;
   localparam int LVL_HI = acpm_pkg::INDEX_W + acpm_pkg::LEVEL_W - 1;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   a_level_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[LVL_HI:LVL_LO] <= acpm_pkg::LEVEL_ONE)
      else $error("level above full scale");

   a_next_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tdata[LVL_LO-1:0] == $past(rsp_tdata[LVL_LO-1:0]) + 3'd1)
      else $error("channel index did not advance within a buffer");

endmodule

bind audio_channel_peak_meter_top acpm_checker u_acpm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- verif/tb_audio_channel_peak_meter_top.sv -----
module tb_audio_channel_peak_meter_top;

   typedef struct packed {
      logic [acpm_pkg::SAMPLE_W-1:0] bits;
      logic                          last;
   } sample_item_type;

   typedef struct packed {
      logic [acpm_pkg::INDEX_W-1:0] chan;
      logic [acpm_pkg::LEVEL_W-1:0] level;
      logic                         last;
   } level_item_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [acpm_pkg::SAMPLE_W-1:0]    req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [acpm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [1:0]                       csr_index = '0;
   logic [acpm_pkg::COUNT_REG_W-1:0] csr_wdata = '0;

   audio_channel_peak_meter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the meter: registers, per-channel peaks, frame position
   acpm_pkg::cfg_type             meter_cfg = '{sample_signed: 1'b1,
                                                width_code: acpm_pkg::WIDTH_16,
                                                channel_count: 4'd1,
                                                format_supported: 1'b1};
   logic [acpm_pkg::SAMPLE_W-1:0] peak_hold [acpm_pkg::MAX_CHANNELS];
   int                            frame_slot = 0;

   sample_item_type pending_samples[$];
   level_item_type  expected_levels[$];
   int              mismatch_count = 0;
   int              send_gap = 0;
   int              recv_gap = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            no_idle = 1'b0;

   initial begin
      for (int i = 0; i < acpm_pkg::MAX_CHANNELS; i++) begin
         peak_hold[i] = '0;
      end
   end

   function automatic int active_channels();
      if (meter_cfg.channel_count == '0) begin
         return 1;
      end
      if (int'(meter_cfg.channel_count) > acpm_pkg::MAX_CHANNELS) begin
         return acpm_pkg::MAX_CHANNELS;
      end
      return int'(meter_cfg.channel_count);
   endfunction

   function automatic logic [31:0] full_scale();
      case (meter_cfg.width_code)
         acpm_pkg::WIDTH_8:  return meter_cfg.sample_signed ? 32'h7F : 32'hFF;
         acpm_pkg::WIDTH_16: return meter_cfg.sample_signed ? 32'h7FFF : 32'hFFFF;
         acpm_pkg::WIDTH_32: return meter_cfg.sample_signed ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
         default:            return 32'h0;
      endcase
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] raw);
      logic [31:0] v;
      logic [31:0] sign;
      case (meter_cfg.width_code)
         acpm_pkg::WIDTH_8: begin
            v    = raw & 32'hFF;
            sign = 32'h80;
         end
         acpm_pkg::WIDTH_16: begin
            v    = raw & 32'hFFFF;
            sign = 32'h8000;
         end
         default: begin
            v    = raw;
            sign = 32'h8000_0000;
         end
      endcase
      if (meter_cfg.sample_signed && (v & sign) != 0) begin
         return sign - (v - sign);
      end
      return v;
   endfunction

   function automatic logic [acpm_pkg::LEVEL_W-1:0] level_of(input logic [31:0] peak,
                                                             input logic [31:0] fs);
      logic [63:0] num;
      logic [63:0] twice;
      logic [63:0] q;
      if (!meter_cfg.format_supported || fs == 0) begin
         return '0;
      end
      if (meter_cfg.sample_signed) begin
         num = 64'(peak);
      end else begin
         twice = 64'(peak) * 2;
         num   = (twice >= 64'(fs)) ? twice - 64'(fs) : 64'(fs) - twice;
      end
      q = (num << acpm_pkg::FRAC_W) / 64'(fs);
      if (q > 64'(acpm_pkg::LEVEL_ONE)) begin
         q = 64'(acpm_pkg::LEVEL_ONE);
      end
      return q[acpm_pkg::LEVEL_W-1:0];
   endfunction

   task automatic take_sample(input logic [31:0] raw, input logic last);
      int             cnt;
      int             p;
      logic [31:0]    m;
      level_item_type e;
      cnt = active_channels();
      p   = frame_slot;
      if (p >= cnt) begin
         p = 0;
      end
      m = magnitude(raw);
      if (m > peak_hold[p]) begin
         peak_hold[p] = m;
      end
      p++;
      if (p >= cnt) begin
         p = 0;
      end
      frame_slot = p;
      if (last) begin
         for (int i = 0; i < cnt; i++) begin
            e.chan  = i[acpm_pkg::INDEX_W-1:0];
            e.level = level_of(peak_hold[i], full_scale());
            e.last  = (i == cnt - 1);
            expected_levels.push_back(e);
         end
         for (int i = 0; i < acpm_pkg::MAX_CHANNELS; i++) begin
            peak_hold[i] = '0;
         end
         frame_slot = 0;
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      sample_item_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0 && !no_idle &&
                         $urandom_range(99) < send_idle_pct) begin
               send_gap = $urandom_range(7, 0);
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               s = pending_samples.pop_front();
               req_tdata  <= s.bits;
               req_tlast  <= s.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // level monitor
   always @(posedge clock) begin
      level_item_type got;
      level_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.chan  = rsp_tdata[acpm_pkg::INDEX_W-1:0];
            got.level = rsp_tdata[acpm_pkg::INDEX_W+acpm_pkg::LEVEL_W-1:acpm_pkg::INDEX_W];
            got.last  = rsp_tlast;
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected level item, expected none, actual chan %0d level %0d",
                        $time, got.chan, got.level);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               if (got.chan !== want.chan) begin
                  $display("%0t: channel_index expected %0d actual %0d",
                           $time, want.chan, got.chan);
                  mismatch_count++;
               end
               if (got.level !== want.level) begin
                  $display("%0t: level (chan %0d) expected %0d actual %0d",
                           $time, want.chan, want.level, got.level);
                  mismatch_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_channel (chan %0d) expected %0d actual %0d",
                           $time, want.chan, want.last, got.last);
                  mismatch_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(99) < recv_idle_pct) begin
            recv_gap = $urandom_range(7, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input acpm_pkg::reg_type idx,
                            input logic [acpm_pkg::COUNT_REG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         acpm_pkg::REG_SIGNED:    meter_cfg.sample_signed    = val[0];
         acpm_pkg::REG_WIDTH:     meter_cfg.width_code = acpm_pkg::width_type'(val[1:0]);
         acpm_pkg::REG_COUNT:     meter_cfg.channel_count    = val;
         acpm_pkg::REG_SUPPORTED: meter_cfg.format_supported = val[0];
      endcase
   endtask

   task automatic push_sample(input logic [31:0] bits, input logic last);
      sample_item_type s;
      s.bits = bits;
      s.last = last;
      pending_samples.push_back(s);
   endtask

   // hold off until all samples are in and all levels are out, then let the engine settle
   task automatic wait_drained(input int settle);
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_levels.size() != 0) begin
         @(negedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] r;
      logic [31:0] top;
      r = $urandom;
      case (meter_cfg.width_code)
         acpm_pkg::WIDTH_8:  top = 32'h80;
         acpm_pkg::WIDTH_16: top = 32'h8000;
         default:            top = 32'h8000_0000;
      endcase
      case ($urandom_range(9))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return top - 1;
         3:       return top;
         4:       return {r[31:8], 8'h01};
         default: return r;
      endcase
   endfunction

   initial begin
      int sent;
      int phase;
      int quota;
      int n;
      int len;
      int cnt;
      logic leave_open;
      logic s_sgn;
      logic s_sup;
      logic [1:0] s_w;
      logic [3:0] s_cnt;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 25;

      // reset format: signed 16-bit, one channel
      push_sample(32'h0000_7FFF, 1'b1);
      push_sample(32'hFFFF_8000, 1'b1);
      wait_drained(40);

      // signed 8-bit stereo, partial last frame, most negative value
      write_reg(acpm_pkg::REG_SIGNED, 4'd1);
      write_reg(acpm_pkg::REG_WIDTH, 4'(acpm_pkg::WIDTH_8));
      write_reg(acpm_pkg::REG_COUNT, 4'd2);
      write_reg(acpm_pkg::REG_SUPPORTED, 4'd1);
      push_sample(32'h0000_007F, 1'b0);
      push_sample(32'h0000_0080, 1'b0);
      push_sample(32'hFFFF_FF81, 1'b1);
      wait_drained(40);

      // unsigned 32-bit, four channels, last channel gets no sample
      write_reg(acpm_pkg::REG_SIGNED, 4'd0);
      write_reg(acpm_pkg::REG_WIDTH, 4'(acpm_pkg::WIDTH_32));
      write_reg(acpm_pkg::REG_COUNT, 4'd4);
      push_sample(32'hFFFF_FFFF, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      wait_drained(40);

      // unsupported format: zero levels
      write_reg(acpm_pkg::REG_SUPPORTED, 4'd0);
      write_reg(acpm_pkg::REG_COUNT, 4'd3);
      push_sample($urandom, 1'b0);
      push_sample($urandom, 1'b0);
      push_sample($urandom, 1'b1);
      wait_drained(40);

      // width code three, channel count zero
      write_reg(acpm_pkg::REG_SUPPORTED, 4'd1);
      write_reg(acpm_pkg::REG_SIGNED, 4'd1);
      write_reg(acpm_pkg::REG_WIDTH, 4'(acpm_pkg::WIDTH_BAD));
      write_reg(acpm_pkg::REG_COUNT, 4'd0);
      push_sample(32'h8000_0000, 1'b1);
      wait_drained(40);

      // unsigned 16-bit, count above the channel limit
      write_reg(acpm_pkg::REG_SIGNED, 4'd0);
      write_reg(acpm_pkg::REG_WIDTH, 4'(acpm_pkg::WIDTH_16));
      write_reg(acpm_pkg::REG_COUNT, 4'd12);
      for (int k = 0; k < 8; k++) begin
         push_sample(k[0] ? 32'h1234_FFFF : 32'h0000_0000 + k * 32'h2000, k == 7);
      end
      wait_drained(40);

      // count and format changed in the middle of a buffer
      write_reg(acpm_pkg::REG_COUNT, 4'd3);
      push_sample(32'h0000_FFFF, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      wait_drained(40);
      write_reg(acpm_pkg::REG_SIGNED, 4'd1);
      write_reg(acpm_pkg::REG_WIDTH, 4'(acpm_pkg::WIDTH_8));
      write_reg(acpm_pkg::REG_COUNT, 4'd2);
      push_sample(32'h0000_0010, 1'b1);
      wait_drained(40);

      sent  = 0;
      phase = 0;
      while (sent < 500) begin
         if (phase == 0) begin
            s_sgn = 1'b1; s_w = acpm_pkg::WIDTH_32; s_cnt = 4'd8; s_sup = 1'b1;
         end else if (phase == 1) begin
            s_sgn = 1'b0; s_w = acpm_pkg::WIDTH_8; s_cnt = 4'd1; s_sup = 1'b1;
         end else begin
            s_sgn = 1'($urandom_range(1));
            s_w   = ($urandom_range(9) == 0) ? acpm_pkg::WIDTH_BAD : 2'($urandom_range(2));
            s_cnt = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) :
                                               4'($urandom_range(8, 1));
            s_sup = ($urandom_range(7) != 0);
         end
         no_idle = (sent >= 420);
         send_idle_pct = no_idle ? 0 : $urandom_range(2) * 25;
         recv_idle_pct = no_idle ? 0 : $urandom_range(2) * 25;
         write_reg(acpm_pkg::REG_SIGNED, 4'(s_sgn));
         write_reg(acpm_pkg::REG_WIDTH, 4'(s_w));
         write_reg(acpm_pkg::REG_COUNT, s_cnt);
         write_reg(acpm_pkg::REG_SUPPORTED, 4'(s_sup));
         cnt        = active_channels();
         quota      = $urandom_range(90, 40);
         leave_open = ($urandom_range(4) == 0);
         n = 0;
         while (n < quota) begin
            len = $urandom_range(3 * cnt + 1, 1);
            for (int k = 0; k < len; k++) begin
               push_sample(pick_sample(),
                           (k == len - 1) && !(leave_open && n + len >= quota));
            end
            n += len;
         end
         sent += n;
         phase++;
         wait_drained(40);
      end

      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
